### rtl/core/msef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msef_pkg;

	localparam int RAW_W   = 16;
	localparam int VALUE_W = 14;
	localparam int DROP_W  = 2;
	localparam int AVG_W   = 28;
	localparam int CNT_W   = 32;
	localparam int CH_W    = 4;
	localparam int SHIFT_W = 4;
	localparam int CFG_W   = 64;

	localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(VALUE_W);

	typedef enum logic {
		MODE_SAMPLE = 1'b0,
		MODE_READ   = 1'b1
	} mode_t;

	typedef struct packed {
		logic [AVG_W-1:0] avg;
		logic [CNT_W-1:0] cnt;
	} entry_t;

endpackage

`default_nettype wire

### rtl/core/msef_state_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module msef_state_mem #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_en,
	input  wire logic [ADDR_W-1:0]   rd_addr,
	output msef_pkg::entry_t         rd_data,
	input  wire logic                wr_en,
	input  wire logic [ADDR_W-1:0]   wr_addr,
	input  wire msef_pkg::entry_t    wr_data
);

	msef_pkg::entry_t mem [DEPTH];
	msef_pkg::entry_t rd_mem_q;
	logic [DEPTH-1:0] valid_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_mem_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// unwritten entries read as zero
	assign rd_data = rd_valid_q ? rd_mem_q : '0;

endmodule

`default_nettype wire

### rtl/core/msef_update.sv
`timescale 1ns / 1ps
`default_nettype none

module msef_update (
	input  wire msef_pkg::entry_t               cur,
	input  wire logic [msef_pkg::SHIFT_W-1:0]   shift_raw,
	input  wire logic [msef_pkg::RAW_W-1:0]     raw_word,
	output msef_pkg::entry_t                    nxt
);

	logic [msef_pkg::SHIFT_W-1:0] k;
	logic [msef_pkg::VALUE_W-1:0] x;
	logic [msef_pkg::AVG_W-1:0]   x_sh;
	logic [msef_pkg::AVG_W-1:0]   a_sh;
	logic [msef_pkg::AVG_W:0]     sum;

	always_comb begin
		k    = (shift_raw > msef_pkg::SHIFT_MAX) ? msef_pkg::SHIFT_MAX : shift_raw;
		x    = raw_word[msef_pkg::RAW_W-1:msef_pkg::DROP_W];
		x_sh = msef_pkg::AVG_W'(x) << (msef_pkg::SHIFT_MAX - k);
		a_sh = cur.avg >> k;
		sum  = {1'b0, cur.avg} - {1'b0, a_sh} + {1'b0, x_sh};
		if (cur.avg == '0) begin
			nxt.avg = {x, {msef_pkg::VALUE_W{1'b0}}};
		end else begin
			nxt.avg = sum[msef_pkg::AVG_W-1:0];
		end
		nxt.cnt = cur.cnt + msef_pkg::CNT_W'(1);
	end

endmodule

`default_nettype wire

### rtl/core/multichannel_shift_ema_filter_bank_core.sv
// Stage 1 registers an accepted request; the output registers then take its result.
// Throughput: one request per cycle unless out_stall stalls the output, set by the
// single read-modify-write pass through the channel state memory (read on accept,
// update and write back on advance, last write forwarded to the following request).
// Reset: arst_n clears pipeline valids, memory valid bits and shift_table; the state
// memory reads as zero until written, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_shift_ema_filter_bank_core #(
	parameter int CHANNELS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [msef_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            mode,
	input  wire logic [msef_pkg::CH_W-1:0]       channel,
	input  wire logic [msef_pkg::RAW_W-1:0]      raw_word,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [msef_pkg::CH_W-1:0]            out_channel,
	output logic [msef_pkg::AVG_W-1:0]           average,
	output logic [msef_pkg::CNT_W-1:0]           sample_count
);

	localparam int IDX_W = $clog2(CHANNELS);

	logic [msef_pkg::CFG_W-1:0] shift_table_q;

	logic                         accept;
	logic                         in_range;
	logic                         advance;

	logic                         valid_s1;
	msef_pkg::mode_t              mode_s1;
	logic [msef_pkg::CH_W-1:0]    channel_s1;
	logic [msef_pkg::RAW_W-1:0]   raw_s1;
	logic                         in_range_s1;
	logic [IDX_W-1:0]             addr_s1;

	logic                         fwd_valid_q;
	logic [IDX_W-1:0]             fwd_addr_q;
	msef_pkg::entry_t             fwd_data_q;

	msef_pkg::entry_t             rd_data;
	msef_pkg::entry_t             cur;
	msef_pkg::entry_t             nxt;
	msef_pkg::entry_t             result;
	logic                         wr_en;
	logic [msef_pkg::SHIFT_W-1:0] shift_raw;

	logic                         out_valid_q;
	logic [msef_pkg::CH_W-1:0]    out_channel_q;
	logic [msef_pkg::AVG_W-1:0]   average_q;
	logic [msef_pkg::CNT_W-1:0]   sample_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_table_q <= '0;
		end else if (cfg_wen) begin
			shift_table_q <= cfg_wdata;
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign in_range = (32'(channel) < CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= msef_pkg::mode_t'(mode);
			channel_s1  <= channel;
			raw_s1      <= raw_word;
			in_range_s1 <= in_range;
			addr_s1     <= IDX_W'(channel);
		end
	end

	msef_state_mem #(
		.DEPTH  (CHANNELS),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_range),
		.rd_addr (IDX_W'(channel)),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (nxt)
	);

	// forward the write that lands on the same edge as the read
	assign cur = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rd_data;

	assign shift_raw = shift_table_q[{channel_s1, 2'b00} +: msef_pkg::SHIFT_W];

	msef_update u_update (
		.cur       (cur),
		.shift_raw (shift_raw),
		.raw_word  (raw_s1),
		.nxt       (nxt)
	);

	assign wr_en = advance && in_range_s1 && (mode_s1 == msef_pkg::MODE_SAMPLE);

	always_comb begin
		if (!in_range_s1) begin
			result = '0;
		end else if (mode_s1 == msef_pkg::MODE_SAMPLE) begin
			result = nxt;
		end else begin
			result = cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_channel_q  <= channel_s1;
			average_q      <= result.avg;
			sample_count_q <= result.cnt;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_channel  = out_channel_q;
	assign average      = average_q;
	assign sample_count = sample_count_q;

endmodule

`default_nettype wire

### rtl/core/msef_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module msef_checker #(
	parameter int CHANNELS = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [msef_pkg::CH_W-1:0]     out_channel,
	input wire logic [msef_pkg::AVG_W-1:0]    average,
	input wire logic [msef_pkg::CNT_W-1:0]    sample_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_channel) && $stable(average)
			&& $stable(sample_count))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("no result two cycles after request");

	a_out_of_bank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (32'(out_channel) >= CHANNELS) |-> average == '0
			&& sample_count == '0)
		else $error("nonzero state reported for channel outside bank");

endmodule

bind multichannel_shift_ema_filter_bank_core msef_checker #(
	.CHANNELS (CHANNELS)
) u_msef_checker (.*);

`default_nettype wire

### tb/tb_multichannel_shift_ema_filter_bank_core.sv
`timescale 1ns / 1ps

module tb_multichannel_shift_ema_filter_bank_core;
	import msef_pkg::*;

	localparam int BANK_SIZE = 16;
	localparam int PHASE_REQUESTS = 90;

	typedef struct {
		logic [CH_W-1:0]  ch;
		logic [AVG_W-1:0] avg;
		logic [CNT_W-1:0] cnt;
	} report_t;

	class ema_bank_tracker;
		logic [CFG_W-1:0] shifts;
		logic [AVG_W-1:0] avg_mem[BANK_SIZE];
		logic [CNT_W-1:0] cnt_mem[BANK_SIZE];
		report_t          pending[$];
		int               errors;

		function new();
			shifts = '0;
			errors = 0;
			foreach (avg_mem[i]) begin
				avg_mem[i] = '0;
				cnt_mem[i] = '0;
			end
		endfunction

		function void load_shifts(logic [CFG_W-1:0] v);
			shifts = v;
		endfunction

		function void note_request(mode_t m, logic [CH_W-1:0] ch, logic [RAW_W-1:0] raw);
			int          idx;
			logic [31:0] x;
			logic [31:0] a;
			logic [31:0] k;
			report_t     r;
			idx = ch;
			r.ch = ch;
			r.avg = '0;
			r.cnt = '0;
			if (idx < BANK_SIZE) begin
				if (m == MODE_SAMPLE) begin
					x = 32'(raw) >> DROP_W;
					a = 32'(avg_mem[idx]);
					k = 32'(shifts[(idx % 16) * SHIFT_W +: SHIFT_W]);
					if (k > 32'(SHIFT_MAX))
						k = 32'(SHIFT_MAX);
					if (a == 0)
						a = x << VALUE_W;
					else
						a = a - (a >> k) + (x << (VALUE_W - k));
					avg_mem[idx] = a[AVG_W-1:0];
					cnt_mem[idx] = cnt_mem[idx] + 1'b1;
				end
				r.avg = avg_mem[idx];
				r.cnt = cnt_mem[idx];
			end
			pending.push_back(r);
		endfunction

		function void check_report(logic [CH_W-1:0] ch, logic [AVG_W-1:0] avg,
				logic [CNT_W-1:0] cnt);
			report_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result ch %0d avg %h cnt %h, expected none",
					$time, ch, avg, cnt);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (ch !== e.ch) begin
				$display("%0t: out_channel expected %0d got %0d", $time, e.ch, ch);
				errors++;
			end
			if (avg !== e.avg) begin
				$display("%0t: average expected %h got %h", $time, e.avg, avg);
				errors++;
			end
			if (cnt !== e.cnt) begin
				$display("%0t: sample_count expected %h got %h", $time, e.cnt, cnt);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              req_mode = MODE_SAMPLE;
	logic [CH_W-1:0]   req_channel = '0;
	logic [RAW_W-1:0]  req_raw = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CH_W-1:0]   out_channel;
	logic [AVG_W-1:0]  average;
	logic [CNT_W-1:0]  sample_count;

	ema_bank_tracker board;

	int stall_style = 0;
	int stall_left = 0;
	int stall_tick = 0;

	multichannel_shift_ema_filter_bank_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (req_mode),
		.channel     (req_channel),
		.raw_word    (req_raw),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_channel (out_channel),
		.average     (average),
		.sample_count(sample_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wen)
				board.load_shifts(cfg_wdata);
			if (in_valid && !in_stall)
				board.note_request(mode_t'(req_mode), req_channel, req_raw);
			if (out_valid && !out_stall)
				board.check_report(out_channel, average, sample_count);
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left = $urandom_range(40, 300);
		end
		stall_left--;
		stall_tick++;
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 30);
			2: out_stall <= ($urandom_range(0, 99) < 75);
			default: out_stall <= ((stall_tick % 8) < 3);
		endcase
	end

	task automatic send_request(mode_t m, logic [CH_W-1:0] ch, logic [RAW_W-1:0] raw);
		in_valid <= 1'b1;
		req_mode <= m;
		req_channel <= ch;
		req_raw <= raw;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic write_shifts(logic [CFG_W-1:0] v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic wait_idle();
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(int n);
		int              burst;
		int              gap;
		mode_t           m;
		logic [RAW_W-1:0] raw;
		burst = $urandom_range(1, 20);
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m = ($urandom_range(0, 3) == 0) ? MODE_READ : MODE_SAMPLE;
			case ($urandom_range(0, 7))
				0: raw = '0;
				1: raw = '1;
				2: raw = RAW_W'($urandom_range(0, 3));
				default: raw = RAW_W'($urandom);
			endcase
			send_request(m, CH_W'($urandom_range(0, 15)), raw);
			burst--;
		end
		in_valid <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] small_shifts();
		logic [CFG_W-1:0] v;
		for (int i = 0; i < 16; i++)
			v[i*SHIFT_W +: SHIFT_W] = SHIFT_W'($urandom_range(1, 3));
		return v;
	endfunction

	initial begin
		logic [CFG_W-1:0] phase_shifts[5];
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_shifts(64'hFEDC_BA98_7654_3210);
		send_request(MODE_READ, 4'd0, 16'h0000);
		send_request(MODE_READ, 4'd15, 16'hFFFF);
		send_request(MODE_SAMPLE, 4'd0, 16'h0000);
		send_request(MODE_READ, 4'd0, 16'h0000);
		send_request(MODE_SAMPLE, 4'd0, 16'h1234);
		send_request(MODE_SAMPLE, 4'd0, 16'hABCD);
		send_request(MODE_SAMPLE, 4'd1, 16'hFFFF);
		send_request(MODE_SAMPLE, 4'd1, 16'h0000);
		send_request(MODE_SAMPLE, 4'd1, 16'hFFFF);
		send_request(MODE_SAMPLE, 4'd15, 16'hFFFF);
		send_request(MODE_SAMPLE, 4'd15, 16'h0003);
		send_request(MODE_SAMPLE, 4'd15, 16'hFFFF);
		send_request(MODE_SAMPLE, 4'd14, 16'h8000);
		send_request(MODE_SAMPLE, 4'd14, 16'hFFFF);
		send_request(MODE_SAMPLE, 4'd7, 16'hFFFC);
		send_request(MODE_SAMPLE, 4'd7, 16'h0004);
		send_request(MODE_SAMPLE, 4'd8, 16'h5555);
		send_request(MODE_SAMPLE, 4'd8, 16'hAAAA);
		send_request(MODE_READ, 4'd1, 16'hFFFF);
		send_request(MODE_READ, 4'd15, 16'h0000);
		send_request(MODE_READ, 4'd8, 16'h5A5A);
		in_valid <= 1'b0;
		wait_idle();

		phase_shifts[0] = '0;
		phase_shifts[1] = '1;
		phase_shifts[2] = small_shifts();
		phase_shifts[3] = {$urandom, $urandom};
		phase_shifts[4] = 64'h0123_4567_89AB_CDEF;
		foreach (phase_shifts[p]) begin
			write_shifts(phase_shifts[p]);
			run_phase(PHASE_REQUESTS);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
rtl/core/msef_pkg.sv
rtl/core/msef_state_mem.sv
rtl/core/msef_update.sv
rtl/core/multichannel_shift_ema_filter_bank_core.sv
rtl/core/msef_checker.sv
tb/tb_multichannel_shift_ema_filter_bank_core.sv
